// ----- design/duplicate_request_cache_assert.svh -----
// Assertion macros for the checker file of the request cache.
`ifndef DUPLICATE_REQUEST_CACHE_ASSERT_SVH
`define DUPLICATE_REQUEST_CACHE_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define DRC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("request cache assertion failed");

// A signal that must keep its value in the cycle after a condition.
`define DRC_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("request cache value changed while held");

`endif

// ----- design/drc_pkg.sv -----
`timescale 1ns / 1ps

package drc_pkg;

  // Field widths of the request and result items.
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TYPE_W      = 8;
  localparam int unsigned XID_W       = 16;
  localparam int unsigned HANDLE_IO_W = 16;
  localparam int unsigned TIME_W      = 63;
  localparam int unsigned RND_W       = 32;
  localparam int unsigned SLOT_W      = 4;

  // Configuration registers.
  localparam int unsigned CSIZE_W    = 5;
  localparam int unsigned TTL_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL        = 1'b1;

  localparam int unsigned          DEFAULT_SIZE = 8;
  localparam logic [CSIZE_W-1:0]   RESET_CSIZE  = 5'd8;
  localparam logic [TTL_W-1:0]     RESET_TTL    = 32'd5000000;

  // Remainder unit: random word consumed a few bits per cycle.
  localparam int unsigned RDX_BITS  = 4;
  localparam int unsigned RDX_STEPS = RND_W / RDX_BITS;
  localparam int unsigned RDX_CNT_W = $clog2(RDX_STEPS);

  // Request payload, last declared field in the lowest bits.
  typedef struct packed {
    logic                   pad;
    logic [RND_W-1:0]       random_value;
    logic [TIME_W-1:0]      now_us;
    logic [HANDLE_IO_W-1:0] response_handle;
    logic [XID_W-1:0]       xid;
    logic [TYPE_W-1:0]      msg_type;
    logic [MAC_W-1:0]       src_mac;
  } req_data_t;

  // Result payload, last declared field in the lowest bits.
  typedef struct packed {
    logic [3:0]             pad;
    logic [HANDLE_IO_W-1:0] handle_out;
    logic [SLOT_W-1:0]      slot;
  } rsp_data_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request, read entry 0
    logic step;    // advance to the next entry
    logic clear;   // drop the current entry (lookup found it dead)
    logic decide;  // latch the outcome of the walk
    logic commit;  // write the entry on a store, load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;       // 1 = store
    logic at_end;     // walk ran past the active entries
    logic dead;       // current entry unused or expired
    logic match;      // current entry keys equal the request keys
    logic tgt_ready;  // write target known
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// ----- design/drc_ctrl.sv -----
`timescale 1ns / 1ps

module drc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  drc_pkg::sts_t sts_i,
  output drc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.at_end) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_FINISH;
        end else if (sts_i.dead) begin
          if (sts_i.mode) begin
            // A store takes the first free or expired entry.
            cmd_o.decide = 1'b1;
            state_d      = ST_FINISH;
          end else begin
            cmd_o.clear = 1'b1;
            cmd_o.step  = 1'b1;
          end
        end else if (!sts_i.mode && sts_i.match) begin
          cmd_o.decide = 1'b1;
          state_d      = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free && sts_i.tgt_ready) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/drc_dp.sv -----
`timescale 1ns / 1ps

module drc_dp #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  drc_pkg::cmd_t                       cmd_i,
  output drc_pkg::sts_t                       sts_o,
  input  logic                                req_mode_i,
  input  drc_pkg::req_data_t                  req_data_i,
  input  logic                                cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_hit_o,
  output drc_pkg::rsp_data_t                  out_data_o
);

  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  localparam int unsigned REM_W    = CNT_W + 1;
  localparam int unsigned DEF_SIZE =
    (ENTRIES < drc_pkg::DEFAULT_SIZE) ? ENTRIES : drc_pkg::DEFAULT_SIZE;
  localparam int unsigned SLOT_W   = drc_pkg::SLOT_W;
  localparam int unsigned HO_W     = drc_pkg::HANDLE_IO_W;
  localparam int unsigned TIME_W   = drc_pkg::TIME_W;
  localparam int unsigned RND_W    = drc_pkg::RND_W;

  typedef struct packed {
    logic [drc_pkg::MAC_W-1:0]  mac;
    logic [drc_pkg::TYPE_W-1:0] msg_type;
    logic [drc_pkg::XID_W-1:0]  xid;
    logic [TIME_W-1:0]          expiry;
    logic [HANDLE_BITS-1:0]     handle;
  } entry_t;

  // Configuration registers.
  logic [drc_pkg::CSIZE_W-1:0] csize_q;
  logic [drc_pkg::TTL_W-1:0]   ttl_q;
  logic [CNT_W-1:0]            size;

  // Request registers.
  logic                       mode_q;
  logic [drc_pkg::MAC_W-1:0]  mac_q;
  logic [drc_pkg::TYPE_W-1:0] type_q;
  logic [drc_pkg::XID_W-1:0]  xid_q;
  logic [HANDLE_BITS-1:0]     handle_q;
  logic [TIME_W-1:0]          now_q;

  // Walk state and entry storage.
  entry_t                     mem [ENTRIES];
  entry_t                     rd_q;
  entry_t                     wr_entry;
  logic [ENTRIES-1:0]         valid_q;
  logic [CNT_W-1:0]           chk_q;
  logic [CNT_W-1:0]           nxt_idx;
  logic                       rd_en;
  logic [IDX_W-1:0]           idx;
  logic                       at_end;
  logic                       dead;
  logic                       match;

  // Outcome of the walk.
  logic                       hit_q;
  logic [IDX_W-1:0]           tgt_q;
  logic                       use_rem_q;
  logic [IDX_W-1:0]           wr_idx;
  logic [IDX_W-1:0]           slot_idx;
  logic [TIME_W:0]            exp_sum;
  logic [TIME_W-1:0]          expiry;

  // Remainder unit.
  logic [RND_W-1:0]                  rnd_q;
  logic [CNT_W-1:0]                  rem_q;
  logic [CNT_W-1:0]                  rem_d;
  logic [drc_pkg::RDX_CNT_W-1:0]     rdx_cnt_q;
  logic                              rdx_busy_q;

  // Result register.
  logic                       out_valid_q;
  logic                       out_hit_q;
  drc_pkg::rsp_data_t         out_data_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csize_q <= drc_pkg::RESET_CSIZE;
      ttl_q   <= drc_pkg::RESET_TTL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        drc_pkg::REG_CACHE_SIZE: csize_q <= cfg_wdata_i[drc_pkg::CSIZE_W-1:0];
        drc_pkg::REG_TTL:        ttl_q   <= cfg_wdata_i[drc_pkg::TTL_W-1:0];
        default: ;
      endcase
    end
  end

  // Active size: zero or beyond the table selects the default.
  always_comb begin
    if (csize_q == '0 || 32'(csize_q) > ENTRIES) begin
      size = CNT_W'(DEF_SIZE);
    end else begin
      size = CNT_W'(csize_q);
    end
  end

  // Capture the request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= req_mode_i;
      mac_q    <= req_data_i.src_mac;
      type_q   <= req_data_i.msg_type;
      xid_q    <= req_data_i.xid;
      handle_q <= HANDLE_BITS'(req_data_i.response_handle);
      now_q    <= req_data_i.now_us;
    end
  end

  // Walk counter: the read of the next entry goes out with each step.
  assign nxt_idx = cmd_i.load ? '0 : chk_q + 1'b1;
  assign rd_en   = (cmd_i.load || cmd_i.step) && (32'(nxt_idx) < ENTRIES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= '0;
    end else if (cmd_i.load || cmd_i.step) begin
      chk_q <= nxt_idx;
    end
  end

  // Entry memory: one read port, one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[nxt_idx[IDX_W-1:0]];
    end
    if (cmd_i.commit && mode_q) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  // Checks on the current entry.
  assign idx    = chk_q[IDX_W-1:0];
  assign at_end = (chk_q >= size);
  assign dead   = !valid_q[idx] || (rd_q.expiry < now_q);
  assign match  = (rd_q.mac == mac_q) && (rd_q.msg_type == type_q) && (rd_q.xid == xid_q);

  // Valid bits: cleared by a lookup that passes a dead entry, set by a store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        valid_q[idx] <= 1'b0;
      end
      if (cmd_i.commit && mode_q) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Outcome of the walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      tgt_q     <= '0;
      use_rem_q <= 1'b0;
    end else if (cmd_i.decide) begin
      hit_q     <= !mode_q && !at_end && !dead && match;
      tgt_q     <= idx;
      use_rem_q <= at_end;
    end
  end

  // Remainder of the random word by the active size, a few bits per cycle.
  always_comb begin
    logic [REM_W-1:0] t;
    logic [CNT_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < drc_pkg::RDX_BITS; j++) begin
      t = {r, rnd_q[RND_W-1-j]};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      r = t[CNT_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdx_busy_q <= 1'b0;
      rdx_cnt_q  <= '0;
      rem_q      <= '0;
      rnd_q      <= '0;
    end else if (cmd_i.load) begin
      rdx_busy_q <= 1'b1;
      rdx_cnt_q  <= drc_pkg::RDX_CNT_W'(drc_pkg::RDX_STEPS - 1);
      rem_q      <= '0;
      rnd_q      <= req_data_i.random_value;
    end else if (rdx_busy_q) begin
      rem_q <= rem_d;
      rnd_q <= rnd_q << drc_pkg::RDX_BITS;
      if (rdx_cnt_q == '0) begin
        rdx_busy_q <= 1'b0;
      end else begin
        rdx_cnt_q <= rdx_cnt_q - 1'b1;
      end
    end
  end

  // Store target and new entry; the expiry saturates at the top of its range.
  assign wr_idx  = use_rem_q ? rem_q[IDX_W-1:0] : tgt_q;
  assign exp_sum = {1'b0, now_q} + (TIME_W + 1)'(ttl_q);
  assign expiry  = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  always_comb begin
    wr_entry.mac      = mac_q;
    wr_entry.msg_type = type_q;
    wr_entry.xid      = xid_q;
    wr_entry.expiry   = expiry;
    wr_entry.handle   = handle_q;
  end

  // Result register.
  assign slot_idx = mode_q ? wr_idx : (hit_q ? tgt_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_hit_q             <= hit_q && !mode_q;
      out_data_q.pad        <= '0;
      out_data_q.slot       <= SLOT_W'(slot_idx);
      out_data_q.handle_out <= (hit_q && !mode_q) ? HO_W'(rd_q.handle) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_data_o  = out_data_q;

  // Status toward the controller.
  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.at_end    = at_end;
    sts_o.dead      = dead;
    sts_o.match     = match;
    sts_o.tgt_ready = !(mode_q && use_rem_q) || !rdx_busy_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ----- design/duplicate_request_cache.sv -----
// The walk reads one entry per cycle through the single registered memory
// read port. A store into a full table also waits for the remainder unit.
// Requests are taken one at a time; the next is taken in the cycle after commit.
// Reset: valid bits clear, cache_size = 8, ttl_us = 5000000; entry data kept.
`timescale 1ns / 1ps

module duplicate_request_cache #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // src_mac, msg_type, xid, response_handle, now_us, random_value, zero pad
  input  drc_pkg::req_data_t              s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot, handle_out, zero pad
  output drc_pkg::rsp_data_t              m_axis_tdata,
  // hit
  output logic                            m_axis_tuser,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [drc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  drc_pkg::cmd_t cmd;
  drc_pkg::sts_t sts;

  // Sequencer for the entry walk.
  drc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entry storage, compare, remainder unit and result register.
  drc_dp #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_mode_i  (s_axis_tuser),
    .req_data_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_hit_o   (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- design/drc_checker.sv -----
`timescale 1ns / 1ps
`include "duplicate_request_cache_assert.svh"

module drc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input drc_pkg::rsp_data_t m_axis_tdata,
  input logic               m_axis_tuser
);

  // A stalled result stays offered and unchanged.
  `DRC_ASSERT(a_out_valid_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `DRC_ASSERT_HOLD(a_out_data_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata)

  // Only one request is in work at a time.
  `DRC_ASSERT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // Misses and stores report no handle.
  `DRC_ASSERT(a_miss_no_handle, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata.handle_out == '0)

endmodule

bind duplicate_request_cache drc_checker u_drc_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import drc_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned NUM_ENTRIES     = 16;
  localparam int unsigned KEY_POOL        = 12;
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 20;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic [HANDLE_IO_W-1:0] handle;
  } reply_t;

  typedef struct packed {
    logic      mode;
    req_data_t data;
    logic      typed;
    reply_t    want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  req_data_t  s_axis_tdata;
  logic       s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  rsp_data_t  m_axis_tdata;
  logic       m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Shadow copy of the cache contents and its two registers.
  logic [CSIZE_W-1:0]     size_reg;
  logic [TTL_W-1:0]       ttl_reg;
  logic                   ent_valid  [NUM_ENTRIES];
  logic [MAC_W-1:0]       ent_mac    [NUM_ENTRIES];
  logic [TYPE_W-1:0]      ent_type   [NUM_ENTRIES];
  logic [XID_W-1:0]       ent_xid    [NUM_ENTRIES];
  logic [TIME_W-1:0]      ent_expiry [NUM_ENTRIES];
  logic [HANDLE_IO_W-1:0] ent_handle [NUM_ENTRIES];

  reply_t      pending_replies[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        no_idle = 1'b0;

  // Keys that the random requests revisit, so that lookups find earlier stores.
  logic [MAC_W-1:0]  pool_mac  [KEY_POOL];
  logic [TYPE_W-1:0] pool_type [KEY_POOL];
  logic [XID_W-1:0]  pool_xid  [KEY_POOL];
  logic [TIME_W-1:0] now_base;

  duplicate_request_cache u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Walk the active entries the way the cache does and return its reply.
  function automatic reply_t predict_reply(input logic mode, input req_data_t r);
    reply_t      rep;
    int unsigned n;
    int unsigned i;
    int unsigned target;
    logic [63:0] sum;
    rep = '0;
    n = {27'd0, size_reg};
    if (n == 0 || n > NUM_ENTRIES) begin
      n = (DEFAULT_SIZE > NUM_ENTRIES) ? NUM_ENTRIES : DEFAULT_SIZE;
    end
    if (mode == MODE_LOOKUP) begin
      // Dead entries are dropped on the way; the walk ends at the first live match.
      for (i = 0; i < n && !rep.hit; i++) begin
        if (!ent_valid[i] || ent_expiry[i] < r.now_us) begin
          ent_valid[i] = 1'b0;
        end else if (ent_mac[i] == r.src_mac && ent_type[i] == r.msg_type &&
                     ent_xid[i] == r.xid) begin
          rep.hit    = 1'b1;
          rep.slot   = i[SLOT_W-1:0];
          rep.handle = ent_handle[i];
        end
      end
    end else begin
      target = n;
      for (i = 0; i < n && target == n; i++) begin
        if (!ent_valid[i] || ent_expiry[i] < r.now_us) begin
          target = i;
        end
      end
      if (target == n) begin
        target = r.random_value % n;
      end
      // The expiry saturates at the top of the time range.
      sum = {1'b0, r.now_us} + 64'(ttl_reg);
      ent_valid[target]  = 1'b1;
      ent_mac[target]    = r.src_mac;
      ent_type[target]   = r.msg_type;
      ent_xid[target]    = r.xid;
      ent_expiry[target] = sum[63] ? TIME_MAX : sum[TIME_W-1:0];
      ent_handle[target] = r.response_handle;
      rep.slot = target[SLOT_W-1:0];
    end
    return rep;
  endfunction

  function automatic void add_row(input logic mode, input logic [MAC_W-1:0] mac,
                                  input logic [TYPE_W-1:0] mtype,
                                  input logic [XID_W-1:0] xid,
                                  input logic [HANDLE_IO_W-1:0] handle,
                                  input logic [TIME_W-1:0] now,
                                  input logic [RND_W-1:0] rnd, input logic typed,
                                  input logic want_hit, input logic [SLOT_W-1:0] want_slot,
                                  input logic [HANDLE_IO_W-1:0] want_handle);
    stim_row_t row;
    row = '0;
    row.mode                 = mode;
    row.data.src_mac         = mac;
    row.data.msg_type        = mtype;
    row.data.xid             = xid;
    row.data.response_handle = handle;
    row.data.now_us          = now;
    row.data.random_value    = rnd;
    row.typed                = typed;
    row.want.hit             = want_hit;
    row.want.slot            = want_slot;
    row.want.handle          = want_handle;
    directed_rows.push_back(row);
  endfunction

  // Present one request after a random gap and record its reply once accepted.
  task automatic send_request(input logic mode, input req_data_t r, input logic typed,
                              input reply_t typed_reply);
    int unsigned gap;
    reply_t      rep;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    rep = predict_reply(mode, r);
    pending_replies.push_back(typed ? typed_reply : rep);
  endtask

  // Hold off new requests until every outstanding reply has come back.
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CACHE_SIZE: size_reg = value[CSIZE_W-1:0];
      REG_TTL:        ttl_reg  = value[TTL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic new_key_pool();
    logic [63:0] wide;
    for (int k = 0; k < KEY_POOL; k++) begin
      wide = {$urandom, $urandom};
      pool_mac[k]  = wide[MAC_W-1:0];
      pool_type[k] = TYPE_W'($urandom);
      pool_xid[k]  = XID_W'($urandom);
    end
  endtask

  // Mostly lookups and stores of pooled keys at a slowly advancing time; the
  // rest is noise: fresh keys, keys one bit off a pooled key, and wild times.
  task automatic make_random_request(output logic mode, output req_data_t r);
    int unsigned pick;
    int unsigned k;
    int unsigned bit_idx;
    int unsigned span;
    logic [71:0] key;
    logic [63:0] wide;
    r    = '0;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, KEY_POOL - 1);
    span = (ttl_reg > 800000) ? 100000 : ttl_reg / 8 + 1;
    now_base += TIME_W'($urandom_range(0, span));
    mode              = (pick < 50) ? MODE_LOOKUP : MODE_STORE;
    r.src_mac         = pool_mac[k];
    r.msg_type        = pool_type[k];
    r.xid             = pool_xid[k];
    r.response_handle = HANDLE_IO_W'($urandom);
    r.random_value    = $urandom;
    r.now_us          = now_base;
    if (pick >= 85) begin
      mode = 1'($urandom_range(0, 1));
      case (pick % 3)
        0: begin
          wide      = {$urandom, $urandom};
          r.src_mac = wide[MAC_W-1:0];
          r.msg_type = TYPE_W'($urandom);
          r.xid      = XID_W'($urandom);
        end
        1: begin
          key     = {r.src_mac, r.msg_type, r.xid};
          bit_idx = $urandom_range(0, 71);
          key[bit_idx] = ~key[bit_idx];
          {r.src_mac, r.msg_type, r.xid} = key;
        end
        default: begin
          wide = {$urandom, $urandom};
          r.now_us = $urandom_range(0, 1) ? wide[TIME_W-1:0]
                                          : TIME_MAX - TIME_W'($urandom_range(0, 1000));
        end
      endcase
    end
  endtask

  // Watchdog: too long without any accepted request, reply or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reply side: random back-pressure, each reply checked against the oldest one due.
  initial begin : reply_sink
    reply_t      want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected reply: hit %0b slot %0d handle %h",
                   m_axis_tuser, m_axis_tdata.slot, m_axis_tdata.handle_out);
        end
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.hit || m_axis_tdata.slot !== want.slot ||
            m_axis_tdata.handle_out !== want.handle) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("reply mismatch: expected hit %0b slot %0d handle %h, %s",
                     want.hit, want.slot, want.handle, "got");
            $display("  hit %0b slot %0d handle %h",
                     m_axis_tuser, m_axis_tdata.slot, m_axis_tdata.handle_out);
          end
        end
      end
    end
  end

  initial begin : request_source
    logic [CSIZE_W-1:0] phase_size [NUM_PHASES];
    logic [TTL_W-1:0]   phase_ttl  [NUM_PHASES];
    logic               mode;
    req_data_t          r;
    logic [63:0]        wide;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOOKUP;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_CACHE_SIZE;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    size_reg      = RESET_CSIZE;
    ttl_reg       = RESET_TTL;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      ent_valid[i]  = 1'b0;
      ent_mac[i]    = '0;
      ent_type[i]   = '0;
      ent_xid[i]    = '0;
      ent_expiry[i] = '0;
      ent_handle[i] = '0;
    end

    // Cache sizes run through zero, one, the full table and values past it.
    phase_size = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd12};
    phase_ttl  = '{32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd200, 32'd5000, 32'd50, 32'd0};
    phase_ttl[NUM_PHASES - 1] = $urandom_range(32'hFFFF_FFFE, 2);

    // Miss on an empty table, store, hit, all-ones key, near-miss key.
    add_row(MODE_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000, 63'd0, 32'd0,
            1'b1, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_STORE, 48'h0, 8'h00, 16'h0000, 16'h1234, 63'd100, 32'd0,
            1'b1, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000, 63'd200, 32'd0,
            1'b1, 1'b1, 4'd0, 16'h1234);
    add_row(MODE_STORE, 48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 63'd300,
            32'hFFFF_FFFF, 1'b1, 1'b0, 4'd1, 16'h0000);
    add_row(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 16'h0000, 63'd400, 32'd0,
            1'b1, 1'b1, 4'd1, 16'hFFFF);
    add_row(MODE_LOOKUP, 48'h0, 8'h01, 16'h0000, 16'h0000, 63'd500, 32'd0,
            1'b1, 1'b0, 4'd0, 16'h0000);
    // Still live exactly at its expiry, dead one microsecond later.
    add_row(MODE_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000, 63'd5_000_100, 32'd0,
            1'b1, 1'b1, 4'd0, 16'h1234);
    add_row(MODE_LOOKUP, 48'h0, 8'h00, 16'h0000, 16'h0000, 63'd5_000_101, 32'd0,
            1'b1, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_STORE, 48'h0A0B_0C0D_0E0F, 8'h5A, 16'hA5A5, 16'h00C3, 63'd5_000_200, 32'd0,
            1'b1, 1'b0, 4'd0, 16'h0000);
    // Fill the default eight entries, then replace by the random word.
    for (int i = 2; i < 8; i++) begin
      add_row(MODE_STORE, 48'h1000_0000_0000 + 48'(i), i[7:0], i[15:0], i[15:0],
              63'd5_000_300, 32'd0, 1'b0, 1'b0, 4'd0, 16'h0000);
    end
    add_row(MODE_STORE, 48'h8000_0000_0001, 8'h80, 16'h8000, 16'h8001, 63'd5_000_300, 32'd0,
            1'b0, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_STORE, 48'h7FFF_FFFF_FFFE, 8'h7F, 16'h7FFF, 16'h7FFE, 63'd5_000_300,
            32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_LOOKUP, 48'h0A0B_0C0D_0E0F, 8'h5A, 16'hA5A5, 16'h0000, 63'd5_000_300, 32'd0,
            1'b0, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_LOOKUP, 48'h8000_0000_0001, 8'h80, 16'h8000, 16'h0000, 63'd5_000_300, 32'd0,
            1'b0, 1'b0, 4'd0, 16'h0000);
    // Store at the top of the time range: the expiry saturates.
    add_row(MODE_STORE, 48'h5555_5555_5555, 8'hAA, 16'h5555, 16'hAAAA, TIME_MAX, 32'd5,
            1'b0, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_LOOKUP, 48'h5555_5555_5555, 8'hAA, 16'h5555, 16'h0000, TIME_MAX, 32'd0,
            1'b0, 1'b0, 4'd0, 16'h0000);
    add_row(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, 16'h0000, TIME_MAX, 32'd0,
            1'b0, 1'b0, 4'd0, 16'h0000);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(REG_CACHE_SIZE, CFG_DATA_W'(RESET_CSIZE));
    write_reg(REG_TTL, RESET_TTL);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].typed,
                   directed_rows[i].want);
    end

    // Random requests, one register setting per phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_reg(REG_CACHE_SIZE, CFG_DATA_W'(phase_size[p]));
      write_reg(REG_TTL, phase_ttl[p]);
      new_key_pool();
      wide     = {$urandom, $urandom};
      now_base = {23'd0, wide[39:0]};
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
        end
        if (n == ITEMS_PER_PHASE / 2 || $urandom_range(0, 149) == 0) begin
          drain_replies();
        end
        make_random_request(mode, r);
        send_request(mode, r, 1'b0, '0);
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
